### hw/rtl/two_wire_led_frame_sender_defines.svh
// Assertion macros shared by the checker of the two-wire LED frame sender.
// No dependencies; included by bare file name.
`ifndef TWO_WIRE_LED_FRAME_SENDER_DEFINES_SVH
`define TWO_WIRE_LED_FRAME_SENDER_DEFINES_SVH

// The consequent must hold at every edge at which the antecedent holds.
`define TLFS_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tlfs implication check failed");

// The expression must never be true at a clock edge.
`define TLFS_ASSERT_NEVER(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("tlfs forbidden condition seen");

`endif

### hw/rtl/tlfs_pkg.sv
// Types, codes and helpers of the two-wire LED frame sender.
// No dependencies; imported by every module of the block.
package tlfs_pkg;

  typedef enum logic {
    OP_TICK,
    OP_FRAME
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_CMD,
    PH_DATA,
    PH_STOP
  } phase_e;

  // Bit index of the acknowledge slot that follows the eight data bits.
  localparam logic [3:0] AckSlot = 4'd8;
  // Last of the four segments of every bit slot or frame condition.
  localparam logic [1:0] LastSeg = 2'd3;
  // Entries held by each of the two queues.
  localparam logic [1:0] QueueFull = 2'd2;

  typedef struct packed {
    op_e        op;
    logic [7:0] cmd_byte;
    logic [7:0] data_byte;
    logic       dio_sense;
  } cmd_t;

  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic dio_driven;
    logic busy_res;
    logic frame_done;
    logic ack_cmd;
    logic ack_data;
  } res_t;

  // True where a segment waits ten delay units rather than five.
  function automatic logic long_wait(phase_e ph, logic [1:0] seg);
    logic r;
    r = 1'b0;
    case (ph)
      PH_START: r = seg[0];
      PH_STOP:  r = (seg != 2'd2);
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/tlfs_front.sv
// Front end of the two-wire LED frame sender: takes requests from the push
// side, classifies them and holds them in a two-entry queue. Uses tlfs_pkg.
module tlfs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  logic           kind_i,
  input  logic [7:0]     cmd_byte_i,
  input  logic [7:0]     data_byte_i,
  input  logic           dio_sense_i,
  output tlfs_pkg::cmd_t cmd_o,
  output logic           cmd_valid_o,
  input  logic           cmd_pop_i
);
  import tlfs_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push_ok, pop_ok;
  cmd_t       entry;

  assign full        = (cnt_q == QueueFull);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign push_ok     = push && !full;
  assign pop_ok      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    entry.op        = kind_i ? OP_FRAME : OP_TICK;
    entry.cmd_byte  = cmd_byte_i;
    entry.data_byte = data_byte_i;
    entry.dio_sense = dio_sense_i;
  end

  always_comb begin
    wr_ptr_d = push_ok ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_ok ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_ok && pop_ok) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### hw/rtl/tlfs_back.sv
// Back end of the two-wire LED frame sender: the waveform sequencer, the
// tick scale register and a two-entry result queue. Uses tlfs_pkg.
module tlfs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  input  tlfs_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  output tlfs_pkg::res_t res_o,
  output logic           empty,
  input  logic           pop
);
  import tlfs_pkg::*;

  logic [7:0]  scale_q;
  phase_e      phase_q, phase_d;
  logic [1:0]  seg_q, seg_d;
  logic [3:0]  bit_q, bit_d;
  logic [11:0] wc_q, wc_d, wc_dec;
  logic [7:0]  shift_q, shift_d, shift_n;
  logic [7:0]  second_q, second_d;
  logic [1:0]  ack_q, ack_d, ack_n;
  logic        clk_q, clk_d, dio_q, dio_d, drv_q, drv_d;
  logic        fire, apply, done;
  logic [7:0]  scale;
  logic [11:0] scale5, scale10;
  res_t        res;

  res_t        omem_q [2];
  logic        owr_q, ord_q;
  logic [1:0]  ocnt_q, ocnt_d;
  logic        opop_ok;

  assign fire      = cmd_valid_i && (ocnt_q != QueueFull);
  assign cmd_pop_o = fire;

  // A zero scale counts as one; waits are five or ten units.
  assign scale   = (scale_q == 8'd0) ? 8'd1 : scale_q;
  assign scale5  = {2'b00, scale, 2'b00} + {4'b0000, scale};
  assign scale10 = {scale5[10:0], 1'b0};

  // Sequencing: segment, bit and phase advance and the wait counter.
  always_comb begin
    phase_d  = phase_q;
    seg_d    = seg_q;
    bit_d    = bit_q;
    shift_n  = shift_q;
    second_d = second_q;
    ack_n    = ack_q;
    wc_dec   = (wc_q != 12'd0) ? (wc_q - 12'd1) : wc_q;
    wc_d     = wc_q;
    apply    = 1'b0;
    done     = 1'b0;
    if (fire) begin
      if (phase_q == PH_IDLE) begin
        if (cmd_i.op == OP_FRAME) begin
          shift_n  = cmd_i.cmd_byte;
          second_d = cmd_i.data_byte;
          ack_n    = 2'b00;
          bit_d    = 4'd0;
          phase_d  = PH_START;
          seg_d    = 2'd0;
          apply    = 1'b1;
        end
      end else if (cmd_i.op == OP_TICK) begin
        wc_d = wc_dec;
        if (wc_dec == 12'd0) begin
          seg_d = seg_q + 2'd1;
          apply = 1'b1;
          if (seg_q == LastSeg) begin
            case (phase_q)
              PH_START: begin
                phase_d = PH_CMD;
                bit_d   = 4'd0;
              end
              PH_CMD, PH_DATA: begin
                if (bit_q == AckSlot) begin
                  bit_d = 4'd0;
                  if (phase_q == PH_CMD) begin
                    phase_d = PH_DATA;
                    shift_n = second_q;
                  end else begin
                    phase_d = PH_STOP;
                  end
                end else begin
                  bit_d = bit_q + 4'd1;
                end
              end
              default: begin
                phase_d = PH_IDLE;
                wc_d    = 12'd0;
                apply   = 1'b0;
                done    = 1'b1;
              end
            endcase
          end
        end
      end
      if (apply) begin
        wc_d = long_wait(phase_d, seg_d) ? scale10 : scale5;
      end
    end
  end

  // Pin actions of the segment just entered, and the acknowledge samples.
  always_comb begin
    clk_d   = clk_q;
    dio_d   = dio_q;
    drv_d   = drv_q;
    shift_d = shift_n;
    ack_d   = ack_n;
    if (apply) begin
      case (phase_d)
        PH_START: begin
          case (seg_d)
            2'd0: begin
              clk_d = 1'b1;
              drv_d = 1'b1;
            end
            2'd1:    dio_d = 1'b1;
            2'd2:    dio_d = 1'b0;
            default: clk_d = 1'b0;
          endcase
        end
        PH_CMD, PH_DATA: begin
          if (bit_d != AckSlot) begin
            case (seg_d)
              2'd0: clk_d = 1'b0;
              2'd1: begin
                dio_d   = shift_n[7];
                shift_d = {shift_n[6:0], 1'b0};
              end
              2'd2:    clk_d = 1'b1;
              default: clk_d = 1'b0;
            endcase
          end else begin
            case (seg_d)
              2'd0: begin
                clk_d = 1'b0;
                drv_d = 1'b0;
                dio_d = 1'b1;
              end
              2'd1: begin
                if (phase_d == PH_CMD) begin
                  ack_d[0] = cmd_i.dio_sense;
                end else begin
                  ack_d[1] = cmd_i.dio_sense;
                end
                drv_d = 1'b1;
                dio_d = 1'b0;
              end
              2'd2:    clk_d = 1'b1;
              default: clk_d = 1'b0;
            endcase
          end
        end
        PH_STOP: begin
          case (seg_d)
            2'd1: begin
              dio_d = 1'b0;
              clk_d = 1'b0;
            end
            2'd2:    clk_d = 1'b1;
            2'd3:    dio_d = 1'b1;
            default: clk_d = clk_q;
          endcase
        end
        default: clk_d = clk_q;
      endcase
    end
  end

  always_comb begin
    res.clk_level  = clk_d;
    res.dio_level  = dio_d;
    res.dio_driven = drv_d;
    res.busy_res   = (phase_d != PH_IDLE);
    res.frame_done = done;
    res.ack_cmd    = ack_d[0];
    res.ack_data   = ack_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= 8'd1;
      phase_q  <= PH_IDLE;
      seg_q    <= 2'd0;
      bit_q    <= 4'd0;
      wc_q     <= 12'd0;
      shift_q  <= 8'd0;
      second_q <= 8'd0;
      ack_q    <= 2'b00;
      clk_q    <= 1'b1;
      dio_q    <= 1'b1;
      drv_q    <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      phase_q  <= phase_d;
      seg_q    <= seg_d;
      bit_q    <= bit_d;
      wc_q     <= wc_d;
      shift_q  <= shift_d;
      second_q <= second_d;
      ack_q    <= ack_d;
      clk_q    <= clk_d;
      dio_q    <= dio_d;
      drv_q    <= drv_d;
    end
  end

  // Result queue.
  assign empty   = (ocnt_q == 2'd0);
  assign opop_ok = pop && !empty;
  assign res_o   = omem_q[ord_q];

  always_comb begin
    ocnt_d = ocnt_q;
    if (fire && !opop_ok) begin
      ocnt_d = ocnt_q + 2'd1;
    end else if (!fire && opop_ok) begin
      ocnt_d = ocnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      omem_q[owr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (fire) begin
        owr_q <= ~owr_q;
      end
      if (opop_ok) begin
        ord_q <= ~ord_q;
      end
      ocnt_q <= ocnt_d;
    end
  end

endmodule

### hw/rtl/two_wire_led_frame_sender.sv
// Top level of the two-wire LED frame sender: front end, back end and wiring.
// Depends on tlfs_pkg, tlfs_front and tlfs_back.
//
//   Channel   Handshake        Payload
//   request   push / full      kind_i, cmd_byte_i, data_byte_i, dio_sense_i
//   result    empty / pop      clk_level_o .. ack_data_o (seven single bits)
//   config    cfg_we_i         cfg_wdata_i (tick scale, 8 bits)
//
// One request is taken per clock while full is low; each gives exactly one result.
// A request enters the front queue, then passes the sequencer into the result queue;
// the sequencer waits while the result queue is full.
// Reset clears both queues and puts the pins at clock high, data high, driven.
// Each queue holds two entries, so a stalled result side lets two more requests in
// before full rises; the sequencer steps only when the result queue has room.
module two_wire_led_frame_sender (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic       kind_i,
  input  logic [7:0] cmd_byte_i,
  input  logic [7:0] data_byte_i,
  input  logic       dio_sense_i,
  output logic       empty,
  input  logic       pop,
  output logic       clk_level_o,
  output logic       dio_level_o,
  output logic       dio_driven_o,
  output logic       busy_res_o,
  output logic       frame_done_o,
  output logic       ack_cmd_o,
  output logic       ack_data_o
);
  import tlfs_pkg::*;

  // Classified requests waiting for the sequencer.
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  // Oldest result waiting to be taken.
  res_t res;

  tlfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .kind_i      (kind_i),
    .cmd_byte_i  (cmd_byte_i),
    .data_byte_i (data_byte_i),
    .dio_sense_i (dio_sense_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  // The back end runs the start, byte, acknowledge and stop segments; each
  // segment waits five or ten delay units of tick_scale ticks.
  tlfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res),
    .empty       (empty),
    .pop         (pop)
  );

  assign clk_level_o  = res.clk_level;
  assign dio_level_o  = res.dio_level;
  assign dio_driven_o = res.dio_driven;
  assign busy_res_o   = res.busy_res;
  assign frame_done_o = res.frame_done;
  assign ack_cmd_o    = res.ack_cmd;
  assign ack_data_o   = res.ack_data;

endmodule

### hw/rtl/tlfs_checker.sv
// Port-level checks of the two-wire LED frame sender and their binding.
// Depends on two_wire_led_frame_sender_defines.svh.
`include "two_wire_led_frame_sender_defines.svh"

module tlfs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic full,
  input logic empty,
  input logic clk_level_o,
  input logic dio_level_o,
  input logic dio_driven_o,
  input logic busy_res_o,
  input logic frame_done_o
);

  // The request side only backs up behind a result that is waiting.
  `TLFS_ASSERT_NEVER(a_full_not_empty, clk_i, rst_ni, full && empty)

  // The end of a frame leaves the sender idle.
  `TLFS_ASSERT_IMP(a_done_idle, clk_i, rst_ni, !empty && frame_done_o, !busy_res_o)

  // When idle the bus rests with both lines high and the data line driven.
  `TLFS_ASSERT_IMP(a_idle_pins, clk_i, rst_ni, !empty && !busy_res_o,
    clk_level_o && dio_level_o && dio_driven_o)

  // A released data line is always left at its pulled-up level.
  `TLFS_ASSERT_IMP(a_release_high, clk_i, rst_ni, !empty && !dio_driven_o, dio_level_o)

endmodule

bind two_wire_led_frame_sender tlfs_checker u_tlfs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .full         (full),
  .empty        (empty),
  .clk_level_o  (clk_level_o),
  .dio_level_o  (dio_level_o),
  .dio_driven_o (dio_driven_o),
  .busy_res_o   (busy_res_o),
  .frame_done_o (frame_done_o)
);

### verif/tlfs_frame_checker.sv
`timescale 1ns / 1ps
// Checker for the two-wire LED frame sender: follows the request and result queues,
// predicts the pin waveform of every request and compares it with what the block shows.
// Depends on tlfs_pkg; instantiated beside the block by tb_two_wire_led_frame_sender.
module tlfs_frame_checker
  import tlfs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       push,
  input  logic       full,
  input  logic       kind_i,
  input  logic [7:0] cmd_byte_i,
  input  logic [7:0] data_byte_i,
  input  logic       dio_sense_i,
  input  logic       empty,
  input  logic       pop,
  input  logic       clk_level_i,
  input  logic       dio_level_i,
  input  logic       dio_driven_i,
  input  logic       busy_res_i,
  input  logic       frame_done_i,
  input  logic       ack_cmd_i,
  input  logic       ack_data_i,
  output int         fail_count_o,
  output int         pending_o
);

  localparam logic [3:0] ShortUnits = 4'd5;
  localparam logic [3:0] LongUnits  = 4'd10;

  phase_e      wave_phase;
  logic [1:0]  seg_q;
  logic [3:0]  bit_q;
  logic [11:0] wait_q;
  logic [7:0]  shift_q;
  logic [7:0]  second_q;
  logic [7:0]  scale_q;
  logic [1:0]  acks_q;
  logic        pin_clk_q;
  logic        pin_dio_q;
  logic        pin_drv_q;
  int          fails;
  res_t        pin_states_due[$];

  // A scale of zero counts as one tick per unit.
  function automatic logic [11:0] segment_ticks(input logic [3:0] units);
    logic [7:0] s;
    s = (scale_q == 8'd0) ? 8'd1 : scale_q;
    return units * s;
  endfunction

  // Applies the pin actions of the current segment and loads its wait.
  task automatic enter_segment(input logic sense);
    logic [3:0] units;
    units = ShortUnits;
    case (wave_phase)
      PH_START: begin
        case (seg_q)
          2'd0: begin
            pin_clk_q = 1'b1;
            pin_drv_q = 1'b1;
          end
          2'd1: pin_dio_q = 1'b1;
          2'd2: pin_dio_q = 1'b0;
          default: pin_clk_q = 1'b0;
        endcase
        if (seg_q[0]) units = LongUnits;
      end
      PH_CMD, PH_DATA: begin
        if (bit_q < AckSlot) begin
          case (seg_q)
            2'd0: pin_clk_q = 1'b0;
            2'd1: begin
              pin_dio_q = shift_q[7];
              shift_q   = shift_q << 1;
            end
            2'd2: pin_clk_q = 1'b1;
            default: pin_clk_q = 1'b0;
          endcase
        end else begin
          case (seg_q)
            2'd0: begin
              pin_clk_q = 1'b0;
              pin_drv_q = 1'b0;
              pin_dio_q = 1'b1;
            end
            2'd1: begin
              if (wave_phase == PH_CMD) acks_q[0] = sense;
              else acks_q[1] = sense;
              pin_drv_q = 1'b1;
              pin_dio_q = 1'b0;
            end
            2'd2: pin_clk_q = 1'b1;
            default: pin_clk_q = 1'b0;
          endcase
        end
      end
      PH_STOP: begin
        case (seg_q)
          2'd1: begin
            pin_dio_q = 1'b0;
            pin_clk_q = 1'b0;
          end
          2'd2: pin_clk_q = 1'b1;
          2'd3: pin_dio_q = 1'b1;
          default: ;
        endcase
        if (seg_q != 2'd2) units = LongUnits;
      end
      default: ;
    endcase
    wait_q = segment_ticks(units);
  endtask

  task automatic next_segment(input logic sense, output logic done);
    done = 1'b0;
    if (seg_q != LastSeg) begin
      seg_q = seg_q + 2'd1;
    end else begin
      seg_q = 2'd0;
      case (wave_phase)
        PH_START: begin
          wave_phase = PH_CMD;
          bit_q      = 4'd0;
        end
        PH_CMD, PH_DATA: begin
          if (bit_q == AckSlot) begin
            bit_q = 4'd0;
            if (wave_phase == PH_CMD) begin
              wave_phase = PH_DATA;
              shift_q    = second_q;
            end else begin
              wave_phase = PH_STOP;
            end
          end else begin
            bit_q = bit_q + 4'd1;
          end
        end
        default: begin
          wave_phase = PH_IDLE;
          wait_q     = 12'd0;
          done       = 1'b1;
        end
      endcase
    end
    if (!done) enter_segment(sense);
  endtask

  // Works out the pin state that one accepted request leads to.
  task automatic step_waveform(input op_e op, input logic [7:0] cmd, input logic [7:0] data,
                               input logic sense, output res_t pins);
    logic done;
    done = 1'b0;
    if (wave_phase == PH_IDLE) begin
      if (op == OP_FRAME) begin
        shift_q    = cmd;
        second_q   = data;
        acks_q     = 2'b00;
        bit_q      = 4'd0;
        seg_q      = 2'd0;
        wave_phase = PH_START;
        enter_segment(sense);
      end
    end else if (op == OP_TICK) begin
      if (wait_q != 12'd0) wait_q = wait_q - 12'd1;
      if (wait_q == 12'd0) next_segment(sense, done);
    end
    pins.clk_level  = pin_clk_q;
    pins.dio_level  = pin_dio_q;
    pins.dio_driven = pin_drv_q;
    pins.busy_res   = (wave_phase != PH_IDLE);
    pins.frame_done = done;
    pins.ack_cmd    = acks_q[0];
    pins.ack_data   = acks_q[1];
  endtask

  task automatic compare_pin(input string name, input logic want, input logic got);
    if (want !== got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t due;
    res_t seen;
    if (!rst_ni) begin
      wave_phase = PH_IDLE;
      seg_q      = 2'd0;
      bit_q      = 4'd0;
      wait_q     = 12'd0;
      shift_q    = 8'd0;
      second_q   = 8'd0;
      scale_q    = 8'd1;
      acks_q     = 2'b00;
      pin_clk_q  = 1'b1;
      pin_dio_q  = 1'b1;
      pin_drv_q  = 1'b1;
      fails      = 0;
      pin_states_due.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) scale_q = cfg_wdata_i;
      if (pop && !empty) begin
        seen = {clk_level_i, dio_level_i, dio_driven_i, busy_res_i, frame_done_i,
                ack_cmd_i, ack_data_i};
        if (pin_states_due.size() == 0) begin
          $error("result appeared with no request outstanding");
          fails++;
        end else begin
          due = pin_states_due.pop_front();
          compare_pin("clk_level", due.clk_level, seen.clk_level);
          compare_pin("dio_level", due.dio_level, seen.dio_level);
          compare_pin("dio_driven", due.dio_driven, seen.dio_driven);
          compare_pin("busy_res", due.busy_res, seen.busy_res);
          compare_pin("frame_done", due.frame_done, seen.frame_done);
          compare_pin("ack_cmd", due.ack_cmd, seen.ack_cmd);
          compare_pin("ack_data", due.ack_data, seen.ack_data);
        end
      end
      if (push && !full) begin
        step_waveform(op_e'(kind_i), cmd_byte_i, data_byte_i, dio_sense_i, due);
        pin_states_due.push_back(due);
      end
      fail_count_o <= fails;
      pending_o    <= pin_states_due.size();
    end
  end

endmodule

### verif/tb_two_wire_led_frame_sender.sv
`timescale 1ns / 1ps
// Top of the frame sender testbench: clock, reset, request and result traffic, verdict.
// Depends on tlfs_pkg, two_wire_led_frame_sender and tlfs_frame_checker.
module tb_two_wire_led_frame_sender;
  import tlfs_pkg::*;

  // Sum of every wait in one frame, in delay units: start 30, two bytes of nine
  // slots at 20 each, stop 35. A frame therefore ends after this many units of ticks.
  localparam int FrameUnits = 425;

  // Ticks sent after a frame request at the largest scale. The run stops well
  // inside the first start segment, so only the loaded wait is exercised.
  localparam int BulkTicks = 40;

  // How often a side pauses between requests.
  typedef enum int {
    PACE_NONE,
    PACE_FULL,
    PACE_SPARSE
  } pace_e;

  // How the data pin reads back during a frame.
  typedef enum int {
    SENSE_LOW,
    SENSE_HIGH,
    SENSE_RANDOM
  } sense_e;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic       push;
  logic       full;
  logic       kind_i;
  logic [7:0] cmd_byte_i;
  logic [7:0] data_byte_i;
  logic       dio_sense_i;
  logic       empty;
  logic       pop;
  logic       clk_level_o;
  logic       dio_level_o;
  logic       dio_driven_o;
  logic       busy_res_o;
  logic       frame_done_o;
  logic       ack_cmd_o;
  logic       ack_data_o;
  int         fail_count;
  int         pending;

  pace_e      sender_pace;
  pace_e      sink_pace;
  bit         bulk_frame;
  logic [7:0] scale_now;
  int         offered;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  two_wire_led_frame_sender dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .cmd_byte_i   (cmd_byte_i),
    .data_byte_i  (data_byte_i),
    .dio_sense_i  (dio_sense_i),
    .empty        (empty),
    .pop          (pop),
    .clk_level_o  (clk_level_o),
    .dio_level_o  (dio_level_o),
    .dio_driven_o (dio_driven_o),
    .busy_res_o   (busy_res_o),
    .frame_done_o (frame_done_o),
    .ack_cmd_o    (ack_cmd_o),
    .ack_data_o   (ack_data_o)
  );

  tlfs_frame_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .cmd_byte_i   (cmd_byte_i),
    .data_byte_i  (data_byte_i),
    .dio_sense_i  (dio_sense_i),
    .empty        (empty),
    .pop          (pop),
    .clk_level_i  (clk_level_o),
    .dio_level_i  (dio_level_o),
    .dio_driven_i (dio_driven_o),
    .busy_res_i   (busy_res_o),
    .frame_done_i (frame_done_o),
    .ack_cmd_i    (ack_cmd_o),
    .ack_data_i   (ack_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Idle cycles before the next request or result. The sparse pace mostly runs
  // back to back and only now and then leaves a gap.
  function automatic int draw_gap(input pace_e p);
    int gap;
    gap = 0;
    case (p)
      PACE_FULL:   gap = $urandom_range(0, 8);
      PACE_SPARSE: gap = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 8) : 0;
      default:     gap = 0;
    endcase
    return gap;
  endfunction

  // While the largest scale is in use the sides keep up a brisk pace.
  function automatic pace_e pick_pace(input bit bulk);
    if (bulk) return ($urandom_range(0, 1) != 0) ? PACE_NONE : PACE_SPARSE;
    return pace_e'($urandom_range(0, 2));
  endfunction

  function automatic logic pick_sense(input sense_e s);
    if (s == SENSE_LOW) return 1'b0;
    if (s == SENSE_HIGH) return 1'b1;
    return 1'($urandom);
  endfunction

  // Offers one request and returns at the edge that accepts it. Push is only
  // lowered when a gap follows, so back-to-back requests never see push drop
  // and rise within the same time step.
  task automatic offer(input op_e op, input logic [7:0] cmd, input logic [7:0] data,
                       input logic sense);
    int gap;
    gap = draw_gap(sender_pace);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    kind_i      <= op;
    cmd_byte_i  <= cmd;
    data_byte_i <= data;
    dio_sense_i <= sense;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    offered++;
    if (offered % 64 == 0) sender_pace = pick_pace(bulk_frame);
  endtask

  // Holds the request side quiet until every predicted result has been popped.
  // The first edge is needed because the pending count from the checker is registered.
  task automatic settle();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_scale(input logic [7:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    scale_now = value;
  endtask

  // One frame request followed by exactly the ticks it needs to finish, then a
  // few ticks while idle. The first tick slot always carries a request made while
  // busy, and further ones are sprinkled in; they must be ignored and cost no time.
  task automatic run_frame(input logic [7:0] cmd, input logic [7:0] data, input sense_e sm,
                           input int tail);
    int ticks;
    int n;
    ticks = FrameUnits * ((scale_now == 8'd0) ? 1 : int'(scale_now));
    offer(OP_FRAME, cmd, data, pick_sense(sm));
    for (n = 0; n < ticks; n++) begin
      if (n == 0 || $urandom_range(0, 19) == 0)
        offer(OP_FRAME, 8'($urandom), 8'($urandom), 1'($urandom));
      offer(OP_TICK, 8'($urandom), 8'($urandom), pick_sense(sm));
    end
    repeat (tail) offer(OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // Result side. It pops with its own random pauses, and twice holds off for a
  // long stretch while the sender keeps offering, so both queues fill and full
  // rises; the second hold-off lands inside the second frame.
  initial begin
    int taken;
    int gap;
    taken = 0;
    pop <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (taken == 300 || taken == 700) begin
        pop <= 1'b0;
        repeat (120) @(posedge clk_i);
      end else begin
        gap = draw_gap(sink_pace);
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      taken++;
      if (taken % 50 == 0) sink_pace = pick_pace(bulk_frame);
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 8'd0;
    push        <= 1'b0;
    kind_i      <= OP_TICK;
    cmd_byte_i  <= 8'd0;
    data_byte_i <= 8'd0;
    dio_sense_i <= 1'b0;
    sender_pace = PACE_FULL;
    sink_pace   = PACE_FULL;
    bulk_frame  = 1'b0;
    scale_now   = 8'd1;
    offered     = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Ticks while idle must leave the pins at their reset levels.
    offer(OP_TICK, 8'h00, 8'h00, 1'b0);
    offer(OP_TICK, 8'hFF, 8'hFF, 1'b1);

    // First frame at the reset scale, all ones then all zeros on the wire, with
    // the data line reading high so both acknowledge bits come back as one.
    run_frame(8'hFF, 8'h00, SENSE_HIGH, 2);

    // A zero scale must behave as one; the line reads low this time.
    write_scale(8'd0);
    sender_pace = pick_pace(1'b0);
    run_frame(8'h00, 8'hFF, SENSE_LOW, 3);

    // Largest scale: a frame is started and given a short burst of ticks, which
    // must all fall inside the five-unit first wait of the start condition.
    write_scale(8'd255);
    bulk_frame  = 1'b1;
    sender_pace = PACE_NONE;
    sink_pace   = PACE_SPARSE;
    offer(OP_FRAME, 8'($urandom), 8'($urandom), 1'($urandom));
    repeat (BulkTicks) offer(OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
    bulk_frame  = 1'b0;
    sender_pace = PACE_FULL;
    sink_pace   = PACE_FULL;

    settle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake; far beyond the slowest legal run.
  initial begin
    #100_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
